### hdl/tce_pkg.sv
// Shared constants, action codes and the scroll command type of the text console engine.
// No dependencies.
package tce_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Width of a cell count that covers the largest screen the ports allow (128 x 32 cells)
    localparam int SHIFT_W = 16;

    // Action codes
    localparam logic [2:0] ACT_PUT_CHAR   = 3'd0;
    localparam logic [2:0] ACT_SET_COLOR  = 3'd1;
    localparam logic [2:0] ACT_WRITE_CELL = 3'd2;
    localparam logic [2:0] ACT_SCROLL_UP  = 3'd3;
    localparam logic [2:0] ACT_SCROLL_DN  = 3'd4;
    localparam logic [2:0] ACT_READ_CELL  = 3'd5;

    // Characters and reset values
    localparam logic [7:0]  CH_SPACE    = 8'h20;
    localparam logic [7:0]  CH_NEWLINE  = 8'h0A;
    localparam logic [15:0] RESET_CELL  = 16'h0720;
    localparam logic [7:0]  RESET_COLOR = 8'h07;

    // Scroll request from the control logic to the sequencer
    typedef struct packed {
        logic               start;
        logic               up;
        logic [SHIFT_W-1:0] shift;
        logic [15:0]        blank;
    } scroll_cmd_t;

endpackage

### hdl/tce_cell_mem.sv
// Character cell store: one write port, one registered read port.
// Depends on nothing but its parameters.
module tce_cell_mem #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);

    logic [15:0] mem [DEPTH];

    // Write, and read with the read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/tce_scroll_seq.sv
// Cell-by-cell sequencer for the clearing pass after reset and for scrolls.
// Depends on tce_pkg; drives the cell store's read port and, in the following cycle, its write port.
module tce_scroll_seq
    import tce_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  scroll_cmd_t   cmd,
    output logic          busy,
    output logic [$clog2(ROWS*COLUMNS)-1:0] raddr,
    input  logic [15:0]   rdata,
    output logic          we,
    output logic [$clog2(ROWS*COLUMNS)-1:0] waddr,
    output logic [15:0]   wdata
);

    localparam int TOTAL = ROWS * COLUMNS;
    localparam int AW    = $clog2(TOTAL);
    localparam int CNTW  = AW + 1;

    localparam logic SQ_IDLE = 1'b0;
    localparam logic SQ_RUN  = 1'b1;

    logic            state_reg, state_next;
    logic            clear_reg, clear_next;
    logic            up_reg, up_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [CNTW-1:0] shift_reg, shift_next;
    logic [15:0]     blank_reg, blank_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [AW-1:0]   pend_addr_reg, pend_addr_next;
    logic            pend_blank_reg, pend_blank_next;

    logic [CNTW-1:0] cell_addr;
    logic [CNTW-1:0] src_addr;
    logic            copy;
    logic            last;

    // Destination cell of this step: ascending for up, descending for down
    assign last      = (cnt_reg == CNTW'(TOTAL - 1));
    assign cell_addr = up_reg ? cnt_reg : (CNTW'(TOTAL - 1) - cnt_reg);
    assign copy      = !clear_reg &&
                       (up_reg ? (cell_addr < (CNTW'(TOTAL) - shift_reg))
                               : (cell_addr >= shift_reg));
    assign src_addr  = up_reg ? (cell_addr + shift_reg) : (cell_addr - shift_reg);
    assign raddr     = src_addr[AW-1:0];

    // Write stage: copied data comes back from the store in the cycle after its read
    assign we    = pend_valid_reg;
    assign waddr = pend_addr_reg;
    assign wdata = pend_blank_reg ? (clear_reg ? RESET_CELL : blank_reg) : rdata;
    assign busy  = (state_reg == SQ_RUN) || pend_valid_reg;

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        clear_next      = clear_reg;
        up_next         = up_reg;
        cnt_next        = cnt_reg;
        shift_next      = shift_reg;
        blank_next      = blank_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = cell_addr[AW-1:0];
        pend_blank_next = !copy;
        case (state_reg)
            SQ_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = SQ_RUN;
                    clear_next = 1'b0;
                    up_next    = cmd.up;
                    cnt_next   = '0;
                    shift_next = cmd.shift[CNTW-1:0];
                    blank_next = cmd.blank;
                end
            end
            SQ_RUN:
            begin
                pend_valid_next = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (last)
                begin
                    state_next = SQ_IDLE;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SQ_RUN;
            clear_reg      <= 1'b1;
            up_reg         <= 1'b1;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_reg      <= clear_next;
            up_reg         <= up_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        shift_reg      <= shift_next;
        blank_reg      <= blank_next;
        pend_addr_reg  <= pend_addr_next;
        pend_blank_reg <= pend_blank_next;
    end

endmodule

### hdl/text_console_engine_unit.sv
// Top level of the text console engine: cursor, color, action decode and output register.
// Depends on tce_pkg, tce_cell_mem and tce_scroll_seq.
//
// Usage: one input item carries an action and its operands; each accepted item yields
// exactly one result item with the read cell value (zero except for read cell) and the
// cursor position after the action. Both channels use valid/stall; an item moves at a
// clock edge with valid high and stall low.
// Timing: put char, set color, write cell and scroll by zero produce their result in the
// output register in the cycle after acceptance, and the next item can be taken in the
// very next cycle (one item per cycle) while the output is not stalled. Read cell goes
// through the store's registered read port and then the output register, with input stall
// held high meanwhile. A scroll, or a newline/wrap on the last row, presents its result at
// once but then holds input stall while the sequencer copies and blanks the store one cell
// per cycle (one read and one write port). Reset: the cursor goes to 0,0 and the color to
// 0x07; a clearing pass fills the store with 0x0720, with input stall held high meanwhile.
// Output stall: the output register holds its item; a new item is still accepted in the
// cycle in which the waiting result is taken.
module text_console_engine_unit
    import tce_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [7:0]  char_code,
    input  logic [7:0]  color,
    input  logic [6:0]  column,
    input  logic [4:0]  row,
    input  logic [4:0]  amount,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] cell_data,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_column
);

    localparam int TOTAL = ROWS * COLUMNS;
    localparam int AW    = $clog2(TOTAL);
    localparam int CNTW  = AW + 1;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int NW    = $clog2(ROWS + 1);

    logic [RW-1:0] cur_row_reg, cur_row_next;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [7:0]    color_reg, color_next;
    logic          out_valid_reg;
    logic          rd_wait_reg;
    logic          rd_zero_reg;
    logic [15:0]   out_data_reg;
    logic [4:0]    out_row_reg;
    logic [6:0]    out_col_reg;

    logic          accept;
    logic          cell_in_range;
    logic [AW-1:0] cell_addr;
    logic [AW-1:0] cursor_addr;
    logic [NW-1:0] n_sat;
    logic [NW-1:0] row_wide;
    logic [NW:0]   row_sum;
    logic [CW:0]   col_inc;
    logic          at_last_row;
    logic          line_end;

    logic          top_we;
    logic [AW-1:0] top_waddr;
    logic [15:0]   top_wdata;
    scroll_cmd_t   cmd;

    logic          seq_busy;
    logic [AW-1:0] seq_raddr;
    logic          seq_we;
    logic [AW-1:0] seq_waddr;
    logic [15:0]   seq_wdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [15:0]   mem_rdata;

    // Handshake
    assign in_stall = seq_busy || rd_wait_reg || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    // Addresses, scroll amount and cursor arithmetic
    assign cell_in_range = (32'(column) < COLUMNS) && (32'(row) < ROWS);
    assign cell_addr     = AW'(row) * AW'(COLUMNS) + AW'(column);
    assign cursor_addr   = AW'(cur_row_reg) * AW'(COLUMNS) + AW'(cur_col_reg);
    assign n_sat         = (32'(amount) > ROWS) ? NW'(ROWS) : NW'(amount);
    assign row_wide      = NW'(cur_row_reg);
    assign row_sum       = (NW + 1)'(cur_row_reg) + (NW + 1)'(n_sat);
    assign col_inc       = (CW + 1)'(cur_col_reg) + 1'b1;
    assign at_last_row   = (cur_row_reg == RW'(ROWS - 1));
    assign line_end      = (char_code == CH_NEWLINE) || (col_inc == (CW + 1)'(COLUMNS));

    // Action decode
    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        color_next   = color_reg;
        top_we       = 1'b0;
        top_waddr    = cell_addr;
        top_wdata    = {color, char_code};
        cmd.start    = 1'b0;
        cmd.up       = 1'b1;
        cmd.shift    = SHIFT_W'(COLUMNS);
        cmd.blank    = {color_reg, CH_SPACE};
        case (action)
            ACT_PUT_CHAR:
            begin
                if (char_code != CH_NEWLINE)
                begin
                    top_we       = 1'b1;
                    top_waddr    = cursor_addr;
                    top_wdata    = {color_reg, char_code};
                    cur_col_next = col_inc[CW-1:0];
                end
                // Newline or wrap: column zero, next row or scroll up one
                if (line_end)
                begin
                    cur_col_next = '0;
                    if (at_last_row)
                    begin
                        cmd.start = 1'b1;
                    end
                    else
                    begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end
                end
            end
            ACT_SET_COLOR:
            begin
                color_next = color;
            end
            ACT_WRITE_CELL:
            begin
                top_we = cell_in_range;
            end
            ACT_SCROLL_UP:
            begin
                if (n_sat != '0)
                begin
                    cmd.start    = 1'b1;
                    cmd.shift    = SHIFT_W'(CNTW'(n_sat) * CNTW'(COLUMNS));
                    cur_row_next = (row_wide >= n_sat) ? RW'(row_wide - n_sat) : '0;
                end
            end
            ACT_SCROLL_DN:
            begin
                if (n_sat != '0)
                begin
                    cmd.start    = 1'b1;
                    cmd.up       = 1'b0;
                    cmd.shift    = SHIFT_W'(CNTW'(n_sat) * CNTW'(COLUMNS));
                    cur_row_next = (row_sum < (NW + 1)'(ROWS)) ? RW'(row_sum)
                                                               : RW'(ROWS - 1);
                end
            end
            default:
            begin
            end
        endcase
        cmd.start = cmd.start && accept;
    end

    // Store port sharing: the sequencer owns both ports while busy
    assign mem_we    = seq_we || (accept && top_we);
    assign mem_waddr = seq_we ? seq_waddr : top_waddr;
    assign mem_wdata = seq_we ? seq_wdata : top_wdata;
    assign mem_raddr = seq_busy ? seq_raddr : cell_addr;

    tce_cell_mem #(
        .DEPTH (TOTAL),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tce_scroll_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .busy  (seq_busy),
        .raddr (seq_raddr),
        .rdata (mem_rdata),
        .we    (seq_we),
        .waddr (seq_waddr),
        .wdata (seq_wdata)
    );

    // Cursor, color and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            color_reg     <= RESET_COLOR;
            out_valid_reg <= 1'b0;
            rd_wait_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cur_row_reg <= cur_row_next;
                cur_col_reg <= cur_col_next;
                color_reg   <= color_next;
            end
            if (accept)
            begin
                out_valid_reg <= (action != ACT_READ_CELL);
                rd_wait_reg   <= (action == ACT_READ_CELL);
            end
            else if (rd_wait_reg)
            begin
                out_valid_reg <= 1'b1;
                rd_wait_reg   <= 1'b0;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= '0;
            out_row_reg  <= 5'(cur_row_next);
            out_col_reg  <= 7'(cur_col_next);
            rd_zero_reg  <= !cell_in_range;
        end
        else if (rd_wait_reg)
        begin
            out_data_reg <= rd_zero_reg ? 16'h0000 : mem_rdata;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cell_data     = out_data_reg;
    assign cursor_row    = out_row_reg;
    assign cursor_column = out_col_reg;

endmodule

### hdl/tce_checker.sv
// Port-level checks of the text console engine, bound to the top level.
// Depends on tce_pkg and text_console_engine_unit.
module tce_checker
    import tce_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [2:0]  action,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] cell_data,
    input logic [4:0]  cursor_row,
    input logic [6:0]  cursor_column
);

    logic accept;
    assign accept = in_valid && !in_stall;

    // Non-read items show their result in the next cycle, with zero cell data
    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (action != ACT_READ_CELL) |=> out_valid && (cell_data == 16'h0000))
        else $error("non-read item did not produce a zero-data result next cycle");

    // A read shows its result once the store's read register and then the output register have taken it
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (action == ACT_READ_CELL) |=> !out_valid ##1 out_valid)
        else $error("read item result timing wrong");

    // Cursor stays on screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(cursor_row) < ROWS) && (32'(cursor_column) < COLUMNS))
        else $error("cursor off screen");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cell_data)
            && $stable(cursor_row) && $stable(cursor_column))
        else $error("stalled result changed");

endmodule

bind text_console_engine_unit tce_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tce_checker (.*);
